// ----- src/assert_macros.svh -----
// Assertion macros for the packetizer modules; only the back end includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define RTPFUA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define RTPFUA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/rtpfua_pkg.sv -----
// Types, constants and helpers for the H.264 RTP FU-A packetizer.
package rtpfua_pkg;

    // Field widths fixed by the stream format
    localparam int unsigned FLEN_W   = 20;
    localparam int unsigned TS_W     = 32;
    localparam int unsigned IN_TDATA_W = 64;   // 8 + 20 + 32 = 60, padded to bytes

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_TYPE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SSRC         = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_FRAG     = 2'd3;

    // Register reset values
    localparam logic [6:0]  RST_PAYLOAD_TYPE = 7'd96;
    localparam logic [31:0] RST_SSRC         = 32'd10;
    localparam logic [7:0]  RST_CHANNEL      = 8'd0;
    localparam logic [15:0] RST_MAX_FRAG     = 16'd1400;

    // Protocol constants
    localparam logic [7:0]  NAL_SPS       = 8'h67;
    localparam logic [7:0]  NAL_PPS       = 8'h68;
    localparam logic [7:0]  NAL_SEI       = 8'h06;
    localparam logic [7:0]  NAL_IDR       = 8'h65;
    localparam logic [7:0]  NAL_SLICE_REF = 8'h61;
    localparam logic [7:0]  NAL_SLICE     = 8'h41;
    localparam logic [4:0]  FU_A_TYPE     = 5'd28;
    localparam logic [7:0]  RTP_V2_BYTE   = 8'h80;
    localparam logic [7:0]  INTERLEAVE_MARK = 8'h24;   // '$'
    localparam logic [15:0] MAX_FRAG_CAP  = 16'd65521;
    localparam logic [15:0] SIZE_SINGLE   = 16'd13;    // 12 RTP + NAL header
    localparam logic [15:0] SIZE_FU_A     = 16'd14;    // 12 RTP + FU ind + FU hdr

    // Serializer step positions
    localparam int unsigned STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_NAL_HDR   = 5'd16;
    localparam logic [STEP_W-1:0] STEP_DATA_SNGL = 5'd17;
    localparam logic [STEP_W-1:0] STEP_DATA_FU   = 5'd18;

    // Queue between front and back
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    // One classified item handed from front to back
    typedef struct packed {
        logic        err;     // rejected unit, one error result
        logic        hdr;     // payload byte opens a packet
        logic        frag;    // FU-A packet
        logic        last;    // last packet of the unit (marker, E bit)
        logic        s_bit;   // first fragment of the unit
        logic        pend;    // payload byte closes its packet
        logic [7:0]  data;
        logic [7:0]  nal;
        logic [15:0] size;
        logic [15:0] seq;
        logic [31:0] ts;
    } t_item;

    function automatic logic type_ok(input logic [7:0] h);
        return (h == NAL_SPS) || (h == NAL_PPS) || (h == NAL_SEI) ||
               (h == NAL_IDR) || (h == NAL_SLICE_REF) || (h == NAL_SLICE);
    endfunction

endpackage

// ----- src/rtpfua_front.sv -----
// Front end: accepts NAL bytes, tracks unit state and classifies each byte.
module rtpfua_front #(
    parameter int unsigned LEN_W = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_data,
    input  logic                          i_start,
    input  logic [rtpfua_pkg::FLEN_W-1:0] i_flen,
    input  logic [rtpfua_pkg::TS_W-1:0]   i_ts,
    input  logic [15:0]                   i_max_frag,
    input  logic                          i_q_full,
    output logic                          o_push,
    output rtpfua_pkg::t_item             o_item
);

    logic [15:0]      r_seq;
    logic [31:0]      r_ts;
    logic [LEN_W-1:0] r_rem;
    logic [15:0]      r_fill;
    logic [7:0]       r_nal;
    logic             r_frag;
    logic             r_drop;
    logic             r_first;

    logic             w_accept;
    logic [LEN_W-1:0] w_flen;
    logic             w_bad;
    logic             w_active;
    logic [15:0]      w_maxf;
    logic             w_frag;
    logic [15:0]      w_n;
    logic             w_last;
    logic             w_open;
    logic [15:0]      w_fill_nx;
    logic [15:0]      w_size;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_flen   = i_flen[LEN_W-1:0];
    assign w_bad    = !rtpfua_pkg::type_ok(i_data) || (w_flen == '0);
    assign w_active = !r_drop && (r_rem != '0);
    assign w_open   = (r_fill == 16'd0);

    // Clamp fragment size into 1..cap
    always_comb begin
        if (i_max_frag == 16'd0) begin
            w_maxf = 16'd1;
        end else if (i_max_frag > rtpfua_pkg::MAX_FRAG_CAP) begin
            w_maxf = rtpfua_pkg::MAX_FRAG_CAP;
        end else begin
            w_maxf = i_max_frag;
        end
    end

    assign w_frag = r_first ? (r_rem > LEN_W'(w_maxf)) : r_frag;

    always_comb begin
        if (w_frag && (r_rem >= LEN_W'(w_maxf))) begin
            w_n = w_maxf;
        end else begin
            w_n = r_rem[15:0];
        end
    end

    assign w_last    = (LEN_W'(w_n) == r_rem);
    assign w_size    = w_frag ? (w_n + rtpfua_pkg::SIZE_FU_A) : (w_n + rtpfua_pkg::SIZE_SINGLE);
    assign w_fill_nx = (w_open ? w_n : r_fill) - 16'd1;

    assign o_push = w_accept && (i_start ? w_bad : w_active);

    always_comb begin
        o_item       = '0;
        o_item.err   = i_start;
        o_item.hdr   = !i_start && w_open;
        o_item.frag  = w_frag;
        o_item.last  = w_last;
        o_item.s_bit = r_first;
        o_item.pend  = (w_fill_nx == 16'd0);
        o_item.data  = i_start ? 8'd0 : i_data;
        o_item.nal   = r_nal;
        o_item.size  = w_size;
        o_item.seq   = r_seq;
        o_item.ts    = r_ts;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq   <= '0;
            r_ts    <= '0;
            r_rem   <= '0;
            r_fill  <= '0;
            r_nal   <= '0;
            r_frag  <= 1'b0;
            r_drop  <= 1'b1;
            r_first <= 1'b0;
        end else if (w_accept) begin
            if (i_start) begin
                r_fill <= '0;
                if (w_bad) begin
                    r_drop  <= 1'b1;
                    r_rem   <= '0;
                    r_first <= 1'b0;
                end else begin
                    r_drop  <= 1'b0;
                    r_nal   <= i_data;
                    r_ts    <= i_ts;
                    r_rem   <= w_flen;
                    r_first <= 1'b1;
                    r_frag  <= 1'b0;
                end
            end else if (w_active) begin
                if (w_open) begin
                    r_seq <= r_seq + 16'd1;
                    if (r_first) begin
                        r_frag  <= w_frag;
                        r_first <= 1'b0;
                    end
                end
                r_fill <= w_fill_nx;
                r_rem  <= r_rem - LEN_W'(1);
                if (r_rem == LEN_W'(1)) begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- src/rtpfua_queue.sv -----
// Two-entry item queue between the classifier and the serializer.
module rtpfua_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rtpfua_pkg::t_item i_item,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output rtpfua_pkg::t_item o_head
);

    rtpfua_pkg::t_item                  r_mem [rtpfua_pkg::Q_DEPTH];
    logic [rtpfua_pkg::Q_PTR_W-1:0]     r_wr;
    logic [rtpfua_pkg::Q_PTR_W-1:0]     r_rd;
    logic [rtpfua_pkg::Q_CNT_W-1:0]     r_cnt;
    logic                               w_push;
    logic                               w_pop;

    assign o_full  = (r_cnt == rtpfua_pkg::Q_CNT_W'(rtpfua_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/rtpfua_back.sv -----
// Back end: serializes queued items into interleaved RTP bytes.
`include "assert_macros.svh"

module rtpfua_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  rtpfua_pkg::t_item i_head,
    output logic              o_pop,
    input  logic [6:0]        i_payload_type,
    input  logic [31:0]       i_ssrc,
    input  logic [7:0]        i_channel,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_pkt_start,
    output logic              o_pkt_end,
    output logic              o_err,
    output logic              o_run_last
);

    logic [rtpfua_pkg::STEP_W-1:0] r_step;
    logic                          r_vld;
    logic [7:0]                    r_byte;
    logic                          r_start;
    logic                          r_end;
    logic                          r_err;
    logic                          r_last;

    logic                          w_load;
    logic [rtpfua_pkg::STEP_W-1:0] w_last_step;
    logic                          w_at_data;
    logic [7:0]                    w_byte;
    logic [7:0]                    w_fu_ind;
    logic [7:0]                    w_fu_hdr;

    assign w_load = i_q_valid && (!r_vld || i_ready);
    assign o_pop  = w_load && w_at_data;

    always_comb begin
        if (i_head.err || !i_head.hdr) begin
            w_last_step = '0;
        end else if (i_head.frag) begin
            w_last_step = rtpfua_pkg::STEP_DATA_FU;
        end else begin
            w_last_step = rtpfua_pkg::STEP_DATA_SNGL;
        end
    end

    assign w_at_data = (r_step == w_last_step);
    assign w_fu_ind  = {i_head.nal[7:5], rtpfua_pkg::FU_A_TYPE};
    assign w_fu_hdr  = {i_head.s_bit, i_head.last, 1'b0, i_head.nal[4:0]};

    // Byte at the current step; offsets follow the packet layout
    always_comb begin
        if (i_head.err) begin
            w_byte = 8'd0;
        end else if (w_at_data) begin
            w_byte = i_head.data;
        end else begin
            case (r_step)
                5'd0:    w_byte = rtpfua_pkg::INTERLEAVE_MARK;
                5'd1:    w_byte = i_channel;
                5'd2:    w_byte = i_head.size[15:8];
                5'd3:    w_byte = i_head.size[7:0];
                5'd4:    w_byte = rtpfua_pkg::RTP_V2_BYTE;
                5'd5:    w_byte = {i_head.last, i_payload_type};
                5'd6:    w_byte = i_head.seq[15:8];
                5'd7:    w_byte = i_head.seq[7:0];
                5'd8:    w_byte = i_head.ts[31:24];
                5'd9:    w_byte = i_head.ts[23:16];
                5'd10:   w_byte = i_head.ts[15:8];
                5'd11:   w_byte = i_head.ts[7:0];
                5'd12:   w_byte = i_ssrc[31:24];
                5'd13:   w_byte = i_ssrc[23:16];
                5'd14:   w_byte = i_ssrc[15:8];
                5'd15:   w_byte = i_ssrc[7:0];
                5'd16:   w_byte = i_head.frag ? w_fu_ind : i_head.nal;
                5'd17:   w_byte = w_fu_hdr;
                default: w_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte  <= w_byte;
            r_start <= !i_head.err && i_head.hdr && (r_step == '0);
            r_end   <= !i_head.err && w_at_data && i_head.pend;
            r_err   <= i_head.err;
            r_last  <= w_at_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_step <= '0;
        end else begin
            if (w_load) begin
                r_vld  <= 1'b1;
                r_step <= w_at_data ? '0 : (r_step + 1'b1);
            end else if (i_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    assign o_valid     = r_vld;
    assign o_byte      = r_byte;
    assign o_pkt_start = r_start;
    assign o_pkt_end   = r_end;
    assign o_err       = r_err;
    assign o_run_last  = r_last;

    `RTPFUA_ASSERT(a_step_range, r_step <= rtpfua_pkg::STEP_DATA_FU, "step counter overran")
    `RTPFUA_ASSERT_IMPL(a_mid_pkt_head, r_step != '0, i_q_valid && i_head.hdr && !i_head.err, "head item lost mid-header")
    `RTPFUA_ASSERT_IMPL(a_err_alone, r_vld && r_err, r_last && !r_start && !r_end, "error result not alone")
    `RTPFUA_ASSERT_IMPL(a_start_not_last, r_vld && r_start, !r_last && !r_err, "packet start closed the item")

endmodule

// ----- src/h264_rtp_fua_packetizer.sv -----
// H.264 RTP packetizer, single-NAL and FU-A, RTSP interleaved byte output.
//
// Channel   Dir  Fields (low bit first)
// s_axis    in   tdata: data_byte[7:0] frame_length[27:8] time_stamp[59:28]; tuser: frame_start
// m_axis    out  tdata: out_byte[7:0]; tuser: packet_start, packet_end, error_flag;
//                tlast: run_last
// i_cfg     in   we/addr/wdata: 0 payload_type, 1 ssrc_value, 2 interleave_channel, 3 max_fragment
//
// A payload byte inside a packet gives one output byte; one that opens a packet
// gives 19 (FU-A) or 18 (single NAL) output bytes, set by the byte serializer.
// An error item gives one result; a valid NAL header item gives none.
// The two-item queue takes one more item while the serializer emits a header,
// then input stalls until the header's payload byte leaves the queue.
// The output register holds a result until it is taken; the queue still takes items while not full.
// Reset is synchronous, active low; it clears unit state and the queue.
module h264_rtp_fua_packetizer #(
    parameter int unsigned LENGTH_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // data_byte, frame_length, time_stamp, pad
    input  logic [0:0]  s_axis_tuser,   // frame_start
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [2:0]  m_axis_tuser,   // packet_start, packet_end, error_flag
    output logic        m_axis_tlast,   // run_last
    // configuration
    input  logic                              i_cfg_we,
    input  logic [rtpfua_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]                       i_cfg_wdata
);

    // Only the low LENGTH_BITS of the 20-bit length field count, at most all 20
    localparam int unsigned LEN_W =
        (LENGTH_BITS < rtpfua_pkg::FLEN_W) ? LENGTH_BITS : rtpfua_pkg::FLEN_W;

    logic [6:0]  r_payload_type;
    logic [31:0] r_ssrc;
    logic [7:0]  r_channel;
    logic [15:0] r_max_frag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_type <= rtpfua_pkg::RST_PAYLOAD_TYPE;
            r_ssrc         <= rtpfua_pkg::RST_SSRC;
            r_channel      <= rtpfua_pkg::RST_CHANNEL;
            r_max_frag     <= rtpfua_pkg::RST_MAX_FRAG;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                rtpfua_pkg::REG_PAYLOAD_TYPE: r_payload_type <= i_cfg_wdata[6:0];
                rtpfua_pkg::REG_SSRC:         r_ssrc         <= i_cfg_wdata;
                rtpfua_pkg::REG_CHANNEL:      r_channel      <= i_cfg_wdata[7:0];
                rtpfua_pkg::REG_MAX_FRAG:     r_max_frag     <= i_cfg_wdata[15:0];
                default:                      r_max_frag     <= r_max_frag;
            endcase
        end
    end

    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_valid;
    rtpfua_pkg::t_item w_item;
    rtpfua_pkg::t_item w_head;

    rtpfua_front #(
        .LEN_W (LEN_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_data     (s_axis_tdata[7:0]),
        .i_start    (s_axis_tuser[0]),
        .i_flen     (s_axis_tdata[27:8]),
        .i_ts       (s_axis_tdata[59:28]),
        .i_max_frag (r_max_frag),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_item     (w_item)
    );

    rtpfua_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    rtpfua_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_payload_type (r_payload_type),
        .i_ssrc         (r_ssrc),
        .i_channel      (r_channel),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_byte         (m_axis_tdata),
        .o_pkt_start    (m_axis_tuser[0]),
        .o_pkt_end      (m_axis_tuser[1]),
        .o_err          (m_axis_tuser[2]),
        .o_run_last     (m_axis_tlast)
    );

endmodule

// ----- bench/h264_rtp_fua_packetizer_chk.sv -----
// Scoreboard for the packetizer: predicts the packet byte stream and checks the output.
module h264_rtp_fua_packetizer_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [63:0]                       i_s_tdata,    // data_byte, frame_length,
                                                            // time_stamp, pad
    input  logic [0:0]                        i_s_tuser,    // frame_start
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [7:0]                        i_m_tdata,    // out_byte
    input  logic [2:0]                        i_m_tuser,    // packet_start, packet_end,
                                                            // error_flag
    input  logic                              i_m_tlast,    // run_last
    input  logic                              i_cfg_we,
    input  logic [rtpfua_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [31:0]                       i_cfg_wdata,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int MAX_REPORTS = 30;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       pkt_start;
        logic       pkt_end;
        logic       err;
        logic       run_last;
    } t_stream_byte;

    t_stream_byte stream_q[$];
    t_stream_byte got;
    t_stream_byte want;
    int           fail_cnt;
    int           pending_cnt;

    // register shadows
    logic [6:0]  pt_reg;
    logic [31:0] ssrc_reg;
    logic [7:0]  chan_reg;
    logic [15:0] maxf_reg;

    // unit state
    logic [15:0] seq_num;
    logic [31:0] unit_ts;
    logic [19:0] bytes_left;
    logic [15:0] pkt_fill;
    logic [7:0]  nal_hdr;
    logic        fu_mode;
    logic        dropping;
    logic        first_byte;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pending_cnt;

    function automatic logic nal_accepted(input logic [7:0] h);
        case (h)
            rtpfua_pkg::NAL_SPS, rtpfua_pkg::NAL_PPS, rtpfua_pkg::NAL_SEI,
            rtpfua_pkg::NAL_IDR, rtpfua_pkg::NAL_SLICE_REF, rtpfua_pkg::NAL_SLICE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic ps, input logic pe,
                             input logic er);
        stream_q.push_back(t_stream_byte'{b, ps, pe, er, 1'b0});
    endtask

    // Expected stream bytes for one input item, appended to stream_q.
    task automatic predict_stream(input logic [7:0] d, input logic st,
                                  input logic [19:0] fl, input logic [31:0] ts);
        int          n_before;
        logic [15:0] eff_maxf;
        logic [15:0] n;
        logic [15:0] sz;
        logic        last_pkt;
        logic        s_flag;
        n_before = stream_q.size();
        if (st) begin
            pkt_fill = '0;
            if (!nal_accepted(d) || fl == '0) begin
                dropping   = 1'b1;
                bytes_left = '0;
                first_byte = 1'b0;
                push_byte(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
                dropping   = 1'b0;
                nal_hdr    = d;
                unit_ts    = ts;
                bytes_left = fl;
                first_byte = 1'b1;
                fu_mode    = 1'b0;
            end
        end else if (!dropping && bytes_left != '0) begin
            if (pkt_fill == '0) begin
                eff_maxf = (maxf_reg == '0) ? 16'd1 :
                           (maxf_reg > rtpfua_pkg::MAX_FRAG_CAP) ? rtpfua_pkg::MAX_FRAG_CAP :
                           maxf_reg;
                s_flag = first_byte;
                if (first_byte) begin
                    fu_mode    = (bytes_left > {4'b0, eff_maxf});
                    first_byte = 1'b0;
                end
                if (fu_mode) begin
                    n  = (bytes_left < {4'b0, eff_maxf}) ? bytes_left[15:0] : eff_maxf;
                    sz = rtpfua_pkg::SIZE_FU_A + n;
                end else begin
                    // single packet always fits under the cap, so 16 bits suffice
                    n  = bytes_left[15:0];
                    sz = rtpfua_pkg::SIZE_SINGLE + n;
                end
                last_pkt = ({4'b0, n} == bytes_left);
                push_byte(rtpfua_pkg::INTERLEAVE_MARK, 1'b1, 1'b0, 1'b0);
                push_byte(chan_reg, 1'b0, 1'b0, 1'b0);
                push_byte(sz[15:8], 1'b0, 1'b0, 1'b0);
                push_byte(sz[7:0], 1'b0, 1'b0, 1'b0);
                push_byte(rtpfua_pkg::RTP_V2_BYTE, 1'b0, 1'b0, 1'b0);
                push_byte({last_pkt, pt_reg}, 1'b0, 1'b0, 1'b0);
                push_byte(seq_num[15:8], 1'b0, 1'b0, 1'b0);
                push_byte(seq_num[7:0], 1'b0, 1'b0, 1'b0);
                push_byte(unit_ts[31:24], 1'b0, 1'b0, 1'b0);
                push_byte(unit_ts[23:16], 1'b0, 1'b0, 1'b0);
                push_byte(unit_ts[15:8], 1'b0, 1'b0, 1'b0);
                push_byte(unit_ts[7:0], 1'b0, 1'b0, 1'b0);
                push_byte(ssrc_reg[31:24], 1'b0, 1'b0, 1'b0);
                push_byte(ssrc_reg[23:16], 1'b0, 1'b0, 1'b0);
                push_byte(ssrc_reg[15:8], 1'b0, 1'b0, 1'b0);
                push_byte(ssrc_reg[7:0], 1'b0, 1'b0, 1'b0);
                if (fu_mode) begin
                    push_byte({nal_hdr[7:5], rtpfua_pkg::FU_A_TYPE}, 1'b0, 1'b0, 1'b0);
                    push_byte({s_flag, last_pkt, 1'b0, nal_hdr[4:0]}, 1'b0, 1'b0, 1'b0);
                end else begin
                    push_byte(nal_hdr, 1'b0, 1'b0, 1'b0);
                end
                seq_num  = seq_num + 16'd1;
                pkt_fill = n;
            end
            pkt_fill   = pkt_fill - 16'd1;
            bytes_left = bytes_left - 20'd1;
            push_byte(d, 1'b0, pkt_fill == '0, 1'b0);
            if (bytes_left == '0)
                dropping = 1'b1;
        end
        if (stream_q.size() > n_before)
            stream_q[stream_q.size()-1].run_last = 1'b1;
    endtask

    task automatic note_failure();
        fail_cnt = fail_cnt + 1;
    endtask

    // fields in order: byte, packet start, packet end, error, run last
    task automatic report_mismatch(input t_stream_byte w, input t_stream_byte g);
        $display("%0t: mismatch expected %h %b%b%b%b, actual %h %b%b%b%b", $time,
                 w.byte_val, w.pkt_start, w.pkt_end, w.err, w.run_last,
                 g.byte_val, g.pkt_start, g.pkt_end, g.err, g.run_last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_reg     = rtpfua_pkg::RST_PAYLOAD_TYPE;
            ssrc_reg   = rtpfua_pkg::RST_SSRC;
            chan_reg   = rtpfua_pkg::RST_CHANNEL;
            maxf_reg   = rtpfua_pkg::RST_MAX_FRAG;
            seq_num    = '0;
            unit_ts    = '0;
            bytes_left = '0;
            pkt_fill   = '0;
            nal_hdr    = '0;
            fu_mode    = 1'b0;
            dropping   = 1'b1;
            first_byte = 1'b0;
            stream_q.delete();
            fail_cnt   = 0;
        end else begin
            // results are registered after their item is taken, so check first
            if (i_m_tvalid && i_m_tready) begin
                got = t_stream_byte'{i_m_tdata, i_m_tuser[0], i_m_tuser[1], i_m_tuser[2],
                                     i_m_tlast};
                if (stream_q.size() == 0) begin
                    if (fail_cnt < MAX_REPORTS)
                        $display("%0t: unexpected result byte=%h start=%b end=%b err=%b last=%b",
                                 $time, got.byte_val, got.pkt_start, got.pkt_end, got.err,
                                 got.run_last);
                    note_failure();
                end else begin
                    want = stream_q.pop_front();
                    if (got !== want) begin
                        if (fail_cnt < MAX_REPORTS)
                            report_mismatch(want, got);
                        note_failure();
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    rtpfua_pkg::REG_PAYLOAD_TYPE: pt_reg   = i_cfg_wdata[6:0];
                    rtpfua_pkg::REG_SSRC:         ssrc_reg = i_cfg_wdata;
                    rtpfua_pkg::REG_CHANNEL:      chan_reg = i_cfg_wdata[7:0];
                    rtpfua_pkg::REG_MAX_FRAG:     maxf_reg = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_stream(i_s_tdata[7:0], i_s_tuser[0], i_s_tdata[27:8],
                               i_s_tdata[59:28]);
        end
        pending_cnt <= stream_q.size();
    end

endmodule

// ----- bench/h264_rtp_fua_packetizer_tb.sv -----
// Testbench top for the H.264 RTP FU-A packetizer: stimulus, flow control and verdict.
module h264_rtp_fua_packetizer_tb;

    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake or register write
    localparam int HOLD_OFF_CYCLES = 300;   // long output stall, fills the queue
    localparam int SETTLE_CYCLES   = 40;    // > one 19-byte header burst plus queue
    localparam int PHASE_ITEMS     = 25;    // random items per phase, ~500 items in all
    localparam int NUM_PHASES      = 6;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [63:0]                       s_axis_tdata;   // data_byte, frame_length,
                                                       // time_stamp, pad
    logic [0:0]                        s_axis_tuser;   // frame_start
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [7:0]                        m_axis_tdata;   // out_byte
    logic [2:0]                        m_axis_tuser;   // packet_start, packet_end,
                                                       // error_flag
    logic                              m_axis_tlast;   // run_last
    logic                              i_cfg_we;
    logic [rtpfua_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [31:0]                       i_cfg_wdata;

    int   chk_fail_count;
    int   chk_pending;
    int   items_sent;
    int   idle_cycles;
    logic src_gaps;    // random sender gaps enabled
    logic sink_gaps;   // random receiver stalls enabled
    logic hold_req;    // ask the receiver for one long hold-off

    h264_rtp_fua_packetizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    h264_rtp_fua_packetizer_chk chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .i_m_tlast    (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: ready mostly high, random stall bursts, one long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing items meanwhile.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_req      = 1'b0;
                m_axis_tready = 1'b1;
            end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** h264_rtp_fua_packetizer: FAILED **");
                $finish;
            end
        end
    end

    // One input item. Entered and left at a falling edge; valid drops on return
    // and is raised again by the next call in the same step with blocking writes.
    task automatic send_item(input logic [7:0] d, input logic st, input logic [19:0] fl,
                             input logic [31:0] ts);
        if (src_gaps && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {4'b0, ts, fl, d};
        s_axis_tuser  = st;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // NAL header item then nbytes payload items with random content; the
    // length and timestamp fields of payload items are junk the block ignores.
    task automatic send_unit(input logic [7:0] hdr, input logic [19:0] flen, input int nbytes);
        int i;
        send_item(hdr, 1'b1, flen, $urandom);
        for (i = 0; i < nbytes; i++)
            send_item(8'($urandom), 1'b0, 20'($urandom), $urandom);
        items_sent = items_sent + 1 + nbytes;
    endtask

    // Sender pause: everything drained, then the block's header latency.
    task automatic wait_idle();
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [rtpfua_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [31:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic write_all(input logic [6:0] pt, input logic [31:0] ssrc,
                             input logic [7:0] chan, input logic [15:0] maxf);
        write_reg(rtpfua_pkg::REG_PAYLOAD_TYPE, {25'b0, pt});
        write_reg(rtpfua_pkg::REG_SSRC, ssrc);
        write_reg(rtpfua_pkg::REG_CHANNEL, {24'b0, chan});
        write_reg(rtpfua_pkg::REG_MAX_FRAG, {16'b0, maxf});
    endtask

    function automatic logic [7:0] good_nal();
        case ($urandom_range(0, 5))
            0: return rtpfua_pkg::NAL_SPS;
            1: return rtpfua_pkg::NAL_PPS;
            2: return rtpfua_pkg::NAL_SEI;
            3: return rtpfua_pkg::NAL_IDR;
            4: return rtpfua_pkg::NAL_SLICE_REF;
            default: return rtpfua_pkg::NAL_SLICE;
        endcase
    endfunction

    initial begin
        int          phase;
        int          kind;
        int          max_len;
        int          phase_goal;
        int          len;
        logic [15:0] maxf;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = rtpfua_pkg::REG_PAYLOAD_TYPE;
        i_cfg_wdata   = '0;
        items_sent    = 0;
        src_gaps      = 1'b1;
        sink_gaps     = 1'b1;
        hold_req      = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- directed part, reset register values first ----
        // stray byte before any unit: ignored
        send_item(8'h00, 1'b0, 20'h0, 32'h0);
        // one-byte single-NAL packet, all-ones timestamp and payload
        send_item(rtpfua_pkg::NAL_SPS, 1'b1, 20'd1, 32'hFFFF_FFFF);
        send_item(8'hFF, 1'b0, 20'hFFFFF, 32'h0);
        // two-byte single-NAL packet, zero timestamp
        send_item(rtpfua_pkg::NAL_PPS, 1'b1, 20'd2, 32'h0);
        send_item(8'h00, 1'b0, 20'h0, 32'h0);
        send_item(8'hA5, 1'b0, 20'h5A5A5, 32'h5A5A_5A5A);
        // zero length: rejected, following byte dropped
        send_item(rtpfua_pkg::NAL_SEI, 1'b1, 20'd0, 32'h1234_5678);
        send_item(8'h11, 1'b0, 20'd7, 32'h0);
        // header byte outside the accepted set, F bit high
        send_item(8'hFF, 1'b1, 20'd3, 32'h0);
        wait_idle();

        // extremes of the header fields, tiny fragments
        write_all(7'd127, 32'hFFFF_FFFF, 8'hFF, 16'd2);
        // five bytes: start, middle and end fragments
        send_item(rtpfua_pkg::NAL_IDR, 1'b1, 20'd5, 32'hDEAD_BEEF);
        send_item(8'h01, 1'b0, 20'h0, 32'h0);
        send_item(8'h02, 1'b0, 20'h0, 32'h0);
        send_item(8'h03, 1'b0, 20'h0, 32'h0);
        send_item(8'h04, 1'b0, 20'h0, 32'h0);
        send_item(8'h05, 1'b0, 20'h0, 32'h0);
        // largest length, abandoned with a fragment left open by a new unit
        send_item(rtpfua_pkg::NAL_SLICE_REF, 1'b1, 20'hFFFFF, 32'h0000_0001);
        send_item(8'h80, 1'b0, 20'h0, 32'h0);
        send_item(rtpfua_pkg::NAL_SLICE, 1'b1, 20'd1, 32'h8000_0000);
        send_item(8'h7F, 1'b0, 20'h0, 32'h0);
        // rejected header in the middle of a unit, rest dropped
        send_item(rtpfua_pkg::NAL_SLICE, 1'b1, 20'd3, 32'h0);
        send_item(8'hC3, 1'b0, 20'h0, 32'h0);
        send_item(8'h00, 1'b1, 20'd3, 32'h0);
        send_item(8'h55, 1'b0, 20'h0, 32'h0);

        // ---- random part, one register setting per phase ----
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    maxf = 16'd0;           // behaves as one byte per fragment
                    max_len = 6;
                    write_all(7'd0, 32'h0, 8'h00, maxf);
                end
                1: begin
                    maxf = 16'd8;
                    max_len = 40;
                    write_all(7'd127, 32'hFFFF_FFFF, 8'hFF, maxf);
                end
                2: begin
                    maxf = 16'hFFFF;        // above the cap, clamped
                    max_len = 30;
                    write_all(7'($urandom), $urandom, 8'($urandom), maxf);
                end
                3: begin
                    maxf = rtpfua_pkg::MAX_FRAG_CAP;
                    max_len = 30;
                    write_all(7'($urandom), $urandom, 8'($urandom), maxf);
                end
                4: begin
                    maxf = 16'($urandom_range(1, 20));
                    max_len = 50;
                    write_all(7'($urandom), $urandom, 8'($urandom), maxf);
                end
                default: begin
                    maxf = rtpfua_pkg::RST_MAX_FRAG;
                    max_len = 30;
                    write_all(7'($urandom), $urandom, 8'($urandom), maxf);
                    // tail of the run goes at full rate
                    src_gaps  = 1'b0;
                    sink_gaps = 1'b0;
                end
            endcase

            if (phase == 1) begin
                // receiver holds off while a long fragmented unit keeps coming
                hold_req = 1'b1;
                send_unit(rtpfua_pkg::NAL_IDR, 20'd60, 60);
            end
            if (phase == 2)
                send_unit(good_nal(), 20'd250, 250);  // size field high byte non-zero

            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) begin
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    // well-formed unit
                    len = $urandom_range(1, max_len);
                    send_unit(good_nal(), 20'(len), len);
                end else if (kind < 88) begin
                    // long unit cut short by the next header
                    send_unit(good_nal(), 20'($urandom_range(1, 20'hFFFFF)),
                              $urandom_range(0, 5));
                end else if (kind < 94) begin
                    // zero length, trailing bytes dropped
                    send_unit(good_nal(), 20'd0, $urandom_range(0, 3));
                end else begin
                    // arbitrary header and length
                    send_unit(8'($urandom), 20'($urandom), $urandom_range(0, 3));
                end
            end
        end

        // ---- drain and verdict ----
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (chk_fail_count == 0)
            $display("** h264_rtp_fua_packetizer: PASSED **");
        else
            $display("** h264_rtp_fua_packetizer: FAILED **");
        $finish;
    end

endmodule

// ----- h264_rtp_fua_packetizer.f -----
+incdir+src
src/rtpfua_pkg.sv
src/rtpfua_front.sv
src/rtpfua_queue.sv
src/rtpfua_back.sv
src/h264_rtp_fua_packetizer.sv
bench/h264_rtp_fua_packetizer_chk.sv
bench/h264_rtp_fua_packetizer_tb.sv
